@@ hdl/nue_pkg.sv @@
// ----------------------------------------------------------------------------
// nue_pkg
// Shared types and constants for the Annex B unit extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nue_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_EPB   = 8'h03;

  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_first;
    logic       unit_end;
    logic       run_last;
  } res_item_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_END
  } tail_t;

  // one classified input: held zeros first, then an optional byte or end marker
  typedef struct packed {
    logic [1:0] nzero;
    tail_t      tail;
    logic [7:0] data;
    logic       first;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/nue_front.sv @@
// ----------------------------------------------------------------------------
// nue_front
// Accepts raw bytes, tracks start codes and held zeros, issues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nue_front
  import nue_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      raw_valid,
  output logic           raw_stall,
  input  wire raw_item_t raw_item,
  output logic           cmd_valid,
  output cmd_t           cmd,
  input  wire logic      cmd_full
);

  logic       in_unit, in_unit_next;
  logic [1:0] zero_run, zero_run_next;
  logic       first_pending, first_pending_next;
  logic       accept;
  logic       emit;

  assign raw_stall = cmd_full;
  assign accept    = raw_valid && !cmd_full;

  always_comb begin
    in_unit_next       = in_unit;
    zero_run_next      = zero_run;
    first_pending_next = first_pending;
    emit               = 1'b0;
    cmd.nzero          = 2'd0;
    cmd.tail           = TAIL_NONE;
    cmd.data           = raw_item.in_byte;
    cmd.first          = first_pending;
    if (raw_item.stream_end) begin
      if (in_unit) begin
        emit      = 1'b1;
        cmd.nzero = zero_run;
        cmd.tail  = TAIL_END;
      end
      in_unit_next       = 1'b0;
      zero_run_next      = 2'd0;
      first_pending_next = 1'b0;
    end else if (!in_unit) begin
      if (raw_item.in_byte == BYTE_START && zero_run == ZERO_RUN_MAX) begin
        in_unit_next       = 1'b1;
        zero_run_next      = 2'd0;
        first_pending_next = 1'b1;
      end else if (raw_item.in_byte == BYTE_ZERO) begin
        if (zero_run != ZERO_RUN_MAX) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        zero_run_next = 2'd0;
      end
    end else if (zero_run == ZERO_RUN_MAX &&
                 (raw_item.in_byte == BYTE_ZERO || raw_item.in_byte == BYTE_START)) begin
      // start code or trailing zero inside a unit closes it, held zeros dropped
      emit     = 1'b1;
      cmd.tail = TAIL_END;
      if (raw_item.in_byte == BYTE_START) begin
        zero_run_next      = 2'd0;
        first_pending_next = 1'b1;
      end else begin
        in_unit_next       = 1'b0;
        zero_run_next      = ZERO_RUN_MAX;
        first_pending_next = 1'b0;
      end
    end else if (raw_item.in_byte == BYTE_ZERO) begin
      zero_run_next = zero_run + 2'd1;
    end else if (raw_item.in_byte == BYTE_EPB && zero_run == ZERO_RUN_MAX) begin
      // emulation prevention byte dropped
      emit               = 1'b1;
      cmd.nzero          = zero_run;
      zero_run_next      = 2'd0;
      first_pending_next = 1'b0;
    end else begin
      emit               = 1'b1;
      cmd.nzero          = zero_run;
      cmd.tail           = TAIL_BYTE;
      zero_run_next      = 2'd0;
      first_pending_next = 1'b0;
    end
  end

  assign cmd_valid = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_unit       <= 1'b0;
      zero_run      <= 2'd0;
      first_pending <= 1'b0;
    end else if (accept) begin
      in_unit       <= in_unit_next;
      zero_run      <= zero_run_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nue_queue.sv @@
// ----------------------------------------------------------------------------
// nue_queue
// Small command fifo between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nue_queue
  import nue_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/nue_back.sv @@
// ----------------------------------------------------------------------------
// nue_back
// Expands each command into result items, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nue_back
  import nue_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire cmd_t head_cmd,
  output logic      pop,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_item_t res_item
);

  logic [1:0] idx;
  logic [1:0] total;
  logic       load;
  logic       last;
  res_item_t  item;

  assign total = head_cmd.nzero + ((head_cmd.tail != TAIL_NONE) ? 2'd1 : 2'd0);
  assign last  = (idx == total - 2'd1);
  assign load  = head_valid && (!res_valid || !res_stall);
  assign pop   = load && last;

  always_comb begin
    item.run_last = last;
    if (idx < head_cmd.nzero) begin
      item.out_byte   = BYTE_ZERO;
      item.unit_first = head_cmd.first && (idx == 2'd0);
      item.unit_end   = 1'b0;
    end else if (head_cmd.tail == TAIL_END) begin
      item.out_byte   = BYTE_ZERO;
      item.unit_first = 1'b0;
      item.unit_end   = 1'b1;
    end else begin
      item.out_byte   = head_cmd.data;
      item.unit_first = head_cmd.first && (head_cmd.nzero == 2'd0);
      item.unit_end   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last ? 2'd0 : idx + 2'd1;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item <= item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nal_unit_extractor_top.sv @@
// ----------------------------------------------------------------------------
// nal_unit_extractor_top
// Annex B byte stream to unit payload, emulation prevention bytes removed.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while raw_stall is low. The result side
// emits one item per cycle while res_stall allows it, so a byte that releases
// held zeros (two or three results) holds the output sequencer for one item per
// result, and the input stalls only once the QDEPTH-entry command fifo between
// the classifier and the output sequencer is full. Each result is registered
// in the command fifo and then in the output register.
`timescale 1ns / 1ps
`default_nettype none

module nal_unit_extractor_top
  import nue_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      raw_valid,
  output logic           raw_stall,
  input  wire raw_item_t raw_item,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_item
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  nue_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_item  (raw_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_full  (cmd_full)
  );

  nue_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (cmd_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  nue_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Annex B unit extractor.
// ----------------------------------------------------------------------------
// A short directed stream walks through start codes, emulation prevention
// removal, held zero release, empty units and end of stream. Random start
// codes with random payload and some noise follow. Every accepted byte is run
// through a local model of the parser, and the payload it yields is compared
// field by field with each result transaction. Both sides idle in random
// bursts. The receiver holds off once for a long stretch, and the sender
// waits twice for the payload to drain.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import nue_pkg::*;

  typedef struct {
    raw_item_t item;
    bit        drain;
  } stim_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      raw_valid = 1'b0;
  logic      raw_stall;
  raw_item_t raw_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  nal_unit_extractor_top dut (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_item  (raw_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  stim_t     pending[$];
  res_item_t payload_q[$];
  int        accepted = 0;
  int        errors = 0;
  bit        raw_fired = 1'b0;
  int        raw_gap = 0;
  int        res_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        drain_next = 1'b0;

  // parser state
  bit         unit_open = 1'b0;
  logic [1:0] held_zeros = 2'd0;
  bit         first_due = 1'b0;

  res_item_t  burst[3];
  int         nburst;

  task automatic emit(input logic [7:0] b, input bit is_end);
    res_item_t r;
    r.out_byte   = is_end ? BYTE_ZERO : b;
    r.unit_first = is_end ? 1'b0 : first_due;
    r.unit_end   = is_end;
    r.run_last   = 1'b0;
    if (!is_end) first_due = 1'b0;
    burst[nburst] = r;
    nburst++;
  endtask

  task automatic emit_held();
    for (int k = 0; k < held_zeros; k++) emit(BYTE_ZERO, 1'b0);
  endtask

  // payload produced by one accepted stream transaction
  task automatic parse_byte(input raw_item_t it);
    res_item_t r;
    nburst = 0;
    if (it.stream_end) begin
      if (unit_open) begin
        emit_held();
        emit(BYTE_ZERO, 1'b1);
      end
      unit_open  = 1'b0;
      held_zeros = 2'd0;
      first_due  = 1'b0;
    end else if (!unit_open) begin
      if (it.in_byte == BYTE_START && held_zeros >= ZERO_RUN_MAX) begin
        unit_open  = 1'b1;
        held_zeros = 2'd0;
        first_due  = 1'b1;
      end else if (it.in_byte == BYTE_ZERO) begin
        if (held_zeros < ZERO_RUN_MAX) held_zeros++;
      end else begin
        held_zeros = 2'd0;
      end
    end else if (held_zeros >= ZERO_RUN_MAX && it.in_byte <= BYTE_START) begin
      // start code or trailing zero closes the unit, held zeros dropped
      emit(BYTE_ZERO, 1'b1);
      if (it.in_byte == BYTE_START) begin
        held_zeros = 2'd0;
        first_due  = 1'b1;
      end else begin
        unit_open  = 1'b0;
        held_zeros = ZERO_RUN_MAX;
        first_due  = 1'b0;
      end
    end else if (it.in_byte == BYTE_ZERO) begin
      held_zeros++;
    end else if (it.in_byte == BYTE_EPB && held_zeros >= ZERO_RUN_MAX) begin
      emit_held();
      held_zeros = 2'd0;
    end else begin
      emit_held();
      emit(it.in_byte, 1'b0);
      held_zeros = 2'd0;
    end
    for (int i = 0; i < nburst; i++) begin
      r = burst[i];
      r.run_last = (i == nburst - 1);
      payload_q.push_back(r);
    end
  endtask

  function automatic bit idle_ok();
    return pending.size() > 40 && (accepted / 30) % 3 != 2;
  endfunction

  // sample handshakes, predict and check
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      raw_fired <= 1'b0;
    end else begin
      raw_fired <= raw_valid && !raw_stall;
      if (raw_valid && !raw_stall) begin
        parse_byte(raw_item);
        accepted <= accepted + 1;
      end
      if (res_valid && !res_stall) begin
        if (payload_q.size() == 0) begin
          $error("result transaction with nothing expected: byte %h first %b end %b last %b",
                 res_item.out_byte, res_item.unit_first, res_item.unit_end,
                 res_item.run_last);
          errors++;
        end else begin
          want = payload_q.pop_front();
          if (res_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, res_item.out_byte);
            errors++;
          end
          if (res_item.unit_first !== want.unit_first) begin
            $error("unit_first: expected %b, got %b", want.unit_first, res_item.unit_first);
            errors++;
          end
          if (res_item.unit_end !== want.unit_end) begin
            $error("unit_end: expected %b, got %b", want.unit_end, res_item.unit_end);
            errors++;
          end
          if (res_item.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, res_item.run_last);
            errors++;
          end
        end
      end
    end
  end

  // stream driver
  always @(negedge clk) begin
    stim_t head;
    if (rst) begin
      raw_valid <= 1'b0;
      raw_item  <= '0;
    end else if (!raw_valid || raw_fired) begin
      if (raw_gap > 0) begin
        raw_valid <= 1'b0;
        raw_gap   <= raw_gap - 1;
      end else if (pending.size() == 0) begin
        raw_valid <= 1'b0;
      end else begin
        head = pending[0];
        if (head.drain && payload_q.size() != 0) begin
          raw_valid <= 1'b0;
        end else if (!head.drain && idle_ok() && $urandom_range(0, 4) == 0) begin
          raw_valid <= 1'b0;
          raw_gap   <= $urandom_range(0, 5);
        end else begin
          raw_valid <= 1'b1;
          raw_item  <= head.item;
          void'(pending.pop_front());
        end
      end
    end
  end

  // payload receiver
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (!hold_done && accepted >= 150) begin
      // long hold-off so the block backs up and stalls its input
      res_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= 80;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (res_gap > 0) begin
      res_stall <= 1'b1;
      res_gap   <= res_gap - 1;
    end else if (idle_ok() && $urandom_range(0, 4) == 0) begin
      res_stall <= 1'b1;
      res_gap   <= $urandom_range(0, 5);
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic add(input logic [7:0] b, input bit eos = 1'b0);
    stim_t s;
    s.item.in_byte    = b;
    s.item.stream_end = eos;
    s.drain           = drain_next;
    drain_next        = 1'b0;
    pending.push_back(s);
  endtask

  task automatic add_end();
    add(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return BYTE_ZERO;
      3:       return BYTE_EPB;
      4:       return BYTE_START;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int len;
    bit mid_drain;
    mid_drain = 1'b0;

    // directed stream
    add(8'hFF);
    add(BYTE_ZERO); add(BYTE_ZERO); add(BYTE_START);   // opens a unit
    add(8'h80);                                        // first payload byte
    add(BYTE_ZERO); add(BYTE_ZERO); add(BYTE_EPB);     // emulation byte removed
    add(BYTE_ZERO); add(8'hFF);                        // one held zero released
    add(BYTE_ZERO); add(BYTE_ZERO); add(8'h7F);        // two held zeros released
    add(BYTE_ZERO); add(BYTE_ZERO); add(BYTE_START);   // end marker, next unit open
    add(BYTE_ZERO); add(BYTE_ZERO); add(BYTE_ZERO);    // empty unit, back to search
    add(BYTE_START);
    add(BYTE_START);                                   // 01 with no zeros is payload
    add(BYTE_ZERO); add_end();                         // end of stream in a unit
    add_end();                                         // end of stream while searching
    add(BYTE_ZERO); add(BYTE_ZERO); add(BYTE_START); add_end();

    // random stream, mostly well-formed units
    drain_next = 1'b1;
    while (pending.size() < 260) begin
      if (!mid_drain && pending.size() > 170) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: add(8'($urandom_range(0, 255)));
        1: add_end();
        default: begin
          add(BYTE_ZERO); add(BYTE_ZERO);
          if ($urandom_range(0, 3) == 0) add(BYTE_ZERO);
          add(BYTE_START);
          len = $urandom_range(0, 10);
          for (int i = 0; i < len; i++) add(pick_byte());
        end
      endcase
    end
    add_end();

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || raw_valid) @(posedge clk);
    while (payload_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (payload_q.size() != 0) begin
      $error("%0d expected result transactions never arrived", payload_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** nal_unit_extractor_top: PASSED **");
    end else begin
      $display("** nal_unit_extractor_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** nal_unit_extractor_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
